[hw/rtl/prr_pkg.sv]
package prr_pkg;

  localparam int unsigned WORD_W    = 16;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned SEL_W     = 3;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned RATE_W    = 45;
  localparam int unsigned NUM_CTRL  = 4;

  localparam int unsigned RADIX_BITS = 2;
  localparam int unsigned QUO_W      = 46;
  localparam int unsigned DIV_STEPS  = QUO_W / RADIX_BITS;
  localparam int unsigned CNT_W      = 5;
  localparam int unsigned DVS_W      = 7;
  localparam int unsigned DVS2_W     = 5;
  localparam int unsigned MULT_W     = 14;

  localparam logic [DATA_W-1:0] PARENT_RESET = 32'd24000000;

  localparam logic [CFG_IDX_W-1:0] CFG_REF_RATE      = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE_POSITION = 1'b1;

  localparam logic       ACT_WRITE = 1'b1;
  localparam logic [SEL_W-1:0] SEL_MODE = 3'd4;

  localparam logic [1:0] MODE_NORMAL = 2'd1;
  localparam logic [1:0] MODE_FOUR   = 2'd3;

  localparam int unsigned NF_MSB = 12;
  localparam int unsigned NR_MSB = 13;
  localparam int unsigned NR_LSB = 8;
  localparam int unsigned NO_MSB = 3;
  localparam int unsigned BYPASS_BIT = 0;

  typedef struct packed {
    logic access;
    logic mul;
    logic rem_clr;
    logic div_step;
    logic div_sel;
  } cmd_t;

  typedef struct packed {
    logic bypass;
  } status_t;

endpackage

[hw/rtl/prr_ctrl.sv]
module prr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  prr_pkg::status_t status_i,
  output prr_pkg::cmd_t  cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StDiv1,
    StLoad2,
    StDiv2
  } state_e;

  state_e                      state_q;
  logic [prr_pkg::CNT_W-1:0]   cnt_q;
  logic                        done_q;
  logic                        last_step;

  assign last_step = (cnt_q == prr_pkg::CNT_W'(prr_pkg::DIV_STEPS - 1));

  always_comb begin
    cmd_o          = '0;
    cmd_o.access   = (state_q == StIdle) && start_i;
    cmd_o.mul      = (state_q == StMul);
    cmd_o.rem_clr  = (state_q == StLoad2);
    cmd_o.div_step = (state_q == StDiv1) || (state_q == StDiv2);
    cmd_o.div_sel  = (state_q == StDiv2);
  end

  assign busy_o = (state_q != StIdle);
  assign done_o = done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= ((state_q == StMul) && status_i.bypass) ||
                ((state_q == StDiv2) && last_step);
      unique case (state_q)
        StIdle: begin
          if (start_i) begin
            state_q <= StMul;
          end
        end
        StMul: begin
          cnt_q <= '0;
          if (status_i.bypass) begin
            state_q <= StIdle;
          end else begin
            state_q <= StDiv1;
          end
        end
        StDiv1: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= StLoad2;
          end
        end
        StLoad2: begin
          cnt_q   <= '0;
          state_q <= StDiv2;
        end
        StDiv2: begin
          cnt_q <= cnt_q + 1'b1;
          if (last_step) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

[hw/rtl/prr_dpath.sv]
module prr_dpath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  prr_pkg::cmd_t                       cmd_i,
  output prr_pkg::status_t                    status_o,
  input  logic                                action_i,
  input  logic [prr_pkg::SEL_W-1:0]           reg_select_i,
  input  logic [prr_pkg::DATA_W-1:0]          write_data_i,
  input  logic                                cfg_we_i,
  input  logic [prr_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [prr_pkg::DATA_W-1:0]          cfg_data_i,
  output logic [prr_pkg::WORD_W-1:0]          read_word_o,
  output logic [prr_pkg::RATE_W-1:0]          output_rate_o
);

  logic [prr_pkg::WORD_W-1:0] ctrl_q [prr_pkg::NUM_CTRL];
  logic [prr_pkg::WORD_W-1:0] mode_q;
  logic [prr_pkg::DATA_W-1:0] parent_q;
  logic [3:0]                 pos_q;

  logic [prr_pkg::WORD_W-1:0] word_q;
  logic [prr_pkg::QUO_W-1:0]  quo_q;
  logic [prr_pkg::DVS_W-1:0]  rem_q;
  logic [prr_pkg::DVS_W-1:0]  dv1_q;
  logic [prr_pkg::DVS2_W-1:0] dv2_q;

  logic [prr_pkg::WORD_W-1:0] en_mask;
  logic [prr_pkg::WORD_W-1:0] new_val;
  logic [prr_pkg::WORD_W-1:0] old_word;
  logic [prr_pkg::WORD_W-1:0] upd_word;
  logic [prr_pkg::WORD_W-1:0] acc_word;
  logic                       is_ctrl;
  logic                       is_mode;
  logic                       do_write;

  logic [prr_pkg::WORD_W-1:0] mode_sh;
  logic [1:0]                 mode;
  logic [prr_pkg::MULT_W-1:0] nf_p1;
  logic [prr_pkg::QUO_W-1:0]  product;

  logic [prr_pkg::QUO_W-1:0]  q_nx;
  logic [prr_pkg::DVS_W-1:0]  r_nx;

  assign en_mask  = write_data_i[prr_pkg::DATA_W-1:prr_pkg::WORD_W];
  assign new_val  = write_data_i[prr_pkg::WORD_W-1:0];
  assign is_ctrl  = (reg_select_i < prr_pkg::SEL_W'(prr_pkg::NUM_CTRL));
  assign is_mode  = (reg_select_i == prr_pkg::SEL_MODE);
  assign do_write = (action_i == prr_pkg::ACT_WRITE);
  assign old_word = is_ctrl ? ctrl_q[reg_select_i[1:0]] : mode_q;
  assign upd_word = do_write ? ((old_word & ~en_mask) | (new_val & en_mask)) : old_word;
  assign acc_word = (is_ctrl || is_mode) ? upd_word : '0;

  assign mode_sh = mode_q >> pos_q;
  assign mode    = mode_sh[1:0];
  assign status_o.bypass = ctrl_q[3][prr_pkg::BYPASS_BIT] ||
                           ((mode != prr_pkg::MODE_NORMAL) && (mode != prr_pkg::MODE_FOUR));

  assign nf_p1   = {1'b0, ctrl_q[1][prr_pkg::NF_MSB:0]} + 1'b1;
  assign product = prr_pkg::QUO_W'(parent_q) * prr_pkg::QUO_W'(nf_p1);

  always_comb begin
    logic [prr_pkg::DVS_W:0]   t;
    logic [prr_pkg::DVS_W:0]   d;
    d    = cmd_i.div_sel ? {3'b000, dv2_q} : {1'b0, dv1_q};
    q_nx = quo_q;
    r_nx = rem_q;
    for (int i = 0; i < prr_pkg::RADIX_BITS; i++) begin
      t    = {r_nx, q_nx[prr_pkg::QUO_W-1]};
      q_nx = {q_nx[prr_pkg::QUO_W-2:0], 1'b0};
      if (t >= d) begin
        t       = t - d;
        q_nx[0] = 1'b1;
      end
      r_nx = t[prr_pkg::DVS_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < prr_pkg::NUM_CTRL; i++) begin
        ctrl_q[i] <= '0;
      end
      mode_q   <= '0;
      parent_q <= prr_pkg::PARENT_RESET;
      pos_q    <= '0;
    end else begin
      if (cmd_i.access && do_write) begin
        if (is_ctrl) begin
          ctrl_q[reg_select_i[1:0]] <= upd_word;
        end else if (is_mode) begin
          mode_q <= upd_word;
        end
      end
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          prr_pkg::CFG_REF_RATE:      parent_q <= cfg_data_i;
          prr_pkg::CFG_MODE_POSITION: pos_q    <= cfg_data_i[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.access) begin
      word_q <= acc_word;
    end
    if (cmd_i.mul) begin
      quo_q <= status_o.bypass ? prr_pkg::QUO_W'(parent_q) : product;
      rem_q <= '0;
      dv1_q <= {1'b0, ctrl_q[0][prr_pkg::NR_MSB:prr_pkg::NR_LSB]} + 1'b1;
      dv2_q <= {1'b0, ctrl_q[0][prr_pkg::NO_MSB:0]} + 1'b1;
    end else if (cmd_i.rem_clr) begin
      rem_q <= '0;
    end else if (cmd_i.div_step) begin
      quo_q <= q_nx;
      rem_q <= r_nx;
    end
  end

  assign read_word_o   = word_q;
  assign output_rate_o = quo_q[prr_pkg::RATE_W-1:0];

endmodule

[hw/rtl/pll_rate_register_model.sv]
// PLL register block with rate readback. An access is taken when start_i is high while
// busy_o is low; it updates the selected word at once and then computes the output rate
// from a 32x14 multiply followed by two truncating divisions on one shared radix-4
// divider that retires two quotient bits a cycle. done_o rises once the controller has
// passed through the product step, the first 46-bit quotient, a reload step between the
// two divisions and the second 46-bit quotient (straight after the product step when
// bypass or a mode other than normal or four selects the parent rate); busy_o is low
// again in the strobe cycle, so a new access may start there. read_word_o and
// output_rate_o are valid during the single done_o cycle and are not held for a receiver:
// whatever samples them must do so in that cycle. Configuration writes are taken on any
// cycle with cfg_we_i high.
module pll_rate_register_model (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic                            action_i,
  input  logic [prr_pkg::SEL_W-1:0]       reg_select_i,
  input  logic [prr_pkg::DATA_W-1:0]      write_data_i,
  output logic                            done_o,
  output logic [prr_pkg::WORD_W-1:0]      read_word_o,
  output logic [prr_pkg::RATE_W-1:0]      output_rate_o,
  input  logic                            cfg_we_i,
  input  logic [prr_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [prr_pkg::DATA_W-1:0]      cfg_data_i
);

  prr_pkg::cmd_t    cmd;
  prr_pkg::status_t status;

  prr_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy_o),
    .done_o   (done_o)
  );

  prr_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .action_i      (action_i),
    .reg_select_i  (reg_select_i),
    .write_data_i  (write_data_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .read_word_o   (read_word_o),
    .output_rate_o (output_rate_o)
  );

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o && !done_o))
    else $error("accepted item did not enter processing");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("done strobe longer than one cycle");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($past(busy_o) && !busy_o))
    else $error("done strobe without a finished item");

endmodule
